// File: rtl/stt_pkg.sv
// Shared types and codes for the shared-timer tachometer capture block.
// No dependencies. Used by stt_chan and shared_timer_tach_capture.
package stt_pkg;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_EDGE  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HIGH    = 2'd1;
    localparam logic [1:0] PH_LOW     = 2'd2;
    localparam logic [1:0] PH_LATCHED = 2'd3;

    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_CH0  = 2'd1;
    localparam logic [1:0] HOLD_CH1  = 2'd2;

    localparam logic REG_WRAP_PERIOD  = 1'b0;
    localparam logic REG_STARVE_LIMIT = 1'b1;

    localparam logic [16:0] PERIOD_RESET = 17'd1000;
    localparam logic [15:0] LIMIT_RESET  = 16'd1000;

    typedef struct packed {
        logic [1:0] kind;
        logic       channel;
        logic       rising;
    } stt_in_t;

    typedef struct packed {
        logic        chan_out;
        logic [1:0]  phase;
        logic        done_res;
        logic [15:0] high_ticks;
        logic [15:0] high_wraps;
        logic [15:0] period_ticks;
        logic [15:0] period_wraps;
        logic [1:0]  holder;
    } stt_out_t;

    // Per-channel events decoded by the top level for one word.
    typedef struct packed {
        logic        wrap;
        logic        edge_hit;
        logic        rising;
        logic        clear;
        logic        owns;
        logic        other_owns;
        logic [15:0] ticks;
    } stt_chan_ctrl_t;

    // Channel status after the word, plus ownership events.
    typedef struct packed {
        logic [1:0]  phase;
        logic        done;
        logic [15:0] high_ticks;
        logic [15:0] high_wraps;
        logic [15:0] period_ticks;
        logic [15:0] period_wraps;
        logic        start;
        logic        close;
        logic        starve;
    } stt_chan_stat_t;

endpackage

// File: rtl/stt_chan.sv
// One tachometer capture channel: phase sequence, wrap count and latches.
// Depends on stt_pkg.
module stt_chan
    import stt_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  stt_chan_ctrl_t ctrl,
    input  logic [15:0]    starve_limit,
    output stt_chan_stat_t stat
);

    logic [1:0]  phase_reg, phase_next;
    logic        done_reg, done_next;
    logic [15:0] wraps_reg, wraps_next;
    logic [15:0] high_ticks_reg, high_ticks_next;
    logic [15:0] high_wraps_reg, high_wraps_next;
    logic [15:0] period_ticks_reg, period_ticks_next;
    logic [15:0] period_wraps_reg, period_wraps_next;
    logic        start, close, starve;

    always_comb begin
        phase_next        = phase_reg;
        done_next         = done_reg;
        wraps_next        = wraps_reg;
        high_ticks_next   = high_ticks_reg;
        high_wraps_next   = high_wraps_reg;
        period_ticks_next = period_ticks_reg;
        period_wraps_next = period_wraps_reg;
        start             = 1'b0;
        close             = 1'b0;
        starve            = 1'b0;
        if (ctrl.wrap) begin
            if (!done_reg && wraps_reg != 16'hFFFF) begin
                wraps_next = wraps_reg + 16'd1;
            end
            if (ctrl.owns && wraps_next > starve_limit) begin
                phase_next = PH_IDLE;
                starve     = 1'b1;
            end
        end else if (ctrl.edge_hit) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (ctrl.rising && !ctrl.other_owns) begin
                        phase_next        = PH_HIGH;
                        wraps_next        = 16'd0;
                        high_ticks_next   = 16'd0;
                        period_ticks_next = 16'd0;
                        start             = 1'b1;
                    end
                end
                PH_HIGH: begin
                    if (!ctrl.rising) begin
                        phase_next      = PH_LOW;
                        high_ticks_next = ctrl.ticks;
                        high_wraps_next = wraps_reg;
                    end
                end
                PH_LOW: begin
                    if (ctrl.rising) begin
                        phase_next        = PH_LATCHED;
                        period_ticks_next = ctrl.ticks;
                        period_wraps_next = wraps_reg;
                        close             = 1'b1;
                    end
                end
                default: begin
                    if (ctrl.rising) begin
                        done_next = 1'b1;
                    end
                end
            endcase
        end else if (ctrl.clear) begin
            phase_next = PH_IDLE;
            done_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            done_reg         <= 1'b0;
            wraps_reg        <= 16'd0;
            high_ticks_reg   <= 16'd0;
            high_wraps_reg   <= 16'd0;
            period_ticks_reg <= 16'd0;
            period_wraps_reg <= 16'd0;
        end else begin
            phase_reg        <= phase_next;
            done_reg         <= done_next;
            wraps_reg        <= wraps_next;
            high_ticks_reg   <= high_ticks_next;
            high_wraps_reg   <= high_wraps_next;
            period_ticks_reg <= period_ticks_next;
            period_wraps_reg <= period_wraps_next;
        end
    end

    assign stat.phase        = phase_next;
    assign stat.done         = done_next;
    assign stat.high_ticks   = high_ticks_next;
    assign stat.high_wraps   = high_wraps_next;
    assign stat.period_ticks = period_ticks_next;
    assign stat.period_wraps = period_wraps_next;
    assign stat.start        = start;
    assign stat.close        = close;
    assign stat.starve       = starve;

    // Done is only reachable from the latched phase and clear drops both.
    a_done_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (phase_reg == PH_LATCHED))
        else $error("done set outside latched phase");

    // A measurement starts only from idle.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (phase_reg == PH_IDLE))
        else $error("start outside idle phase");

    // Hold the wrap count once the channel is done.
    a_wraps_held_done: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (wraps_next == wraps_reg))
        else $error("wrap count moved while done");

endmodule

// File: rtl/shared_timer_tach_capture.sv
// Top level of the two-channel fan tachometer capture with one shared timer.
// Depends on stt_pkg and stt_chan.

// Each input word is a timer tick, an edge on one channel or a clear of one
// channel, and each produces exactly one result word: the status of the named
// channel after the update, plus the current timer holder. A word passes an
// input register, then decode and state update, then the result register. A
// new word is taken every cycle while the result side keeps up; a stalled
// result holds the result register and the input register absorbs one more
// word before s_ready drops. Throughput is set by the state update, which is
// combinational (timer increment and compare against the wrap period,
// wrap-count increment and compare against the starvation limit).
// The configuration channel is always ready and must be written only while no
// word is in flight. COUNT_BITS sets the timer width (8 to 32); latched tick
// fields report its low 16 bits.
module shared_timer_tach_capture
    import stt_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  stt_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output stt_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_wdata
);

    localparam int CMP_W  = (COUNT_BITS + 1 > 17) ? COUNT_BITS + 1 : 17;
    localparam int TICK_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // Configuration registers.
    logic [16:0] period_reg;
    logic [15:0] limit_reg;

    // Input register.
    logic    in_valid_reg;
    stt_in_t in_word_reg;

    // Result register.
    logic     out_valid_reg;
    stt_out_t out_word_reg, out_word_next;

    // Shared timer and its owner.
    logic [COUNT_BITS-1:0] timer_reg, timer_next;
    logic [1:0]            owner_reg, owner_next;

    logic                  advance;
    logic                  fire;
    logic [COUNT_BITS:0]   cnt_plus;
    logic                  tmr_wrap;
    logic [TICK_W-1:0]     cnt_ext;
    logic                  is_tick;

    stt_chan_ctrl_t ctrl [2];
    stt_chan_stat_t stat [2];

    // Advance the pipe whenever the result register is free or being taken.
    assign advance   = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
            limit_reg  <= LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WRAP_PERIOD:  period_reg <= cfg_wdata;
                REG_STARVE_LIMIT: limit_reg  <= cfg_wdata[15:0];
                default:          period_reg <= period_reg;
            endcase
        end
    end

    // Input register: load on acceptance, drain when the update fires.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    // Timer wraps when the next count reaches the period or the counter is full.
    assign cnt_plus = {1'b0, timer_reg} + {{COUNT_BITS{1'b0}}, 1'b1};
    assign tmr_wrap = (CMP_W'(cnt_plus) >= CMP_W'(period_reg)) || (&timer_reg);
    assign cnt_ext  = TICK_W'(timer_reg);
    assign is_tick  = fire && (in_word_reg.kind == KIND_TICK);

    // Decode the word into per-channel events.
    for (genvar i = 0; i < 2; i++) begin : g_chan
        localparam logic [1:0] OWN_CODE   = (i == 0) ? HOLD_CH0 : HOLD_CH1;
        localparam logic [1:0] OTHER_CODE = (i == 0) ? HOLD_CH1 : HOLD_CH0;

        assign ctrl[i].wrap       = is_tick && tmr_wrap;
        assign ctrl[i].edge_hit   = fire && (in_word_reg.kind == KIND_EDGE)
                                    && (in_word_reg.channel == 1'(i));
        assign ctrl[i].rising     = in_word_reg.rising;
        assign ctrl[i].clear      = fire && (in_word_reg.kind == KIND_CLEAR)
                                    && (in_word_reg.channel == 1'(i));
        assign ctrl[i].owns       = (owner_reg == OWN_CODE);
        assign ctrl[i].other_owns = (owner_reg == OTHER_CODE);
        assign ctrl[i].ticks      = cnt_ext[15:0];

        stt_chan u_chan (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl[i]),
            .starve_limit (limit_reg),
            .stat         (stat[i])
        );
    end

    // Timer and owner update; an edge or clear reaches only the named channel, a wrap reaches both.
    always_comb begin
        timer_next = timer_reg;
        owner_next = owner_reg;
        if (is_tick) begin
            timer_next = tmr_wrap ? '0 : cnt_plus[COUNT_BITS-1:0];
        end
        if (stat[0].starve || stat[1].starve) begin
            owner_next = HOLD_NONE;
        end
        if (stat[0].start) begin
            owner_next = HOLD_CH0;
            timer_next = '0;
        end
        if (stat[1].start) begin
            owner_next = HOLD_CH1;
            timer_next = '0;
        end
        if (stat[0].close || stat[1].close) begin
            owner_next = HOLD_NONE;
        end
        if (ctrl[0].clear && ctrl[0].owns) begin
            owner_next = HOLD_NONE;
        end
        if (ctrl[1].clear && ctrl[1].owns) begin
            owner_next = HOLD_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg <= '0;
            owner_reg <= HOLD_NONE;
        end else begin
            timer_reg <= timer_next;
            owner_reg <= owner_next;
        end
    end

    // Report the named channel after the update.
    always_comb begin
        out_word_next.chan_out     = in_word_reg.channel;
        out_word_next.phase        = stat[in_word_reg.channel].phase;
        out_word_next.done_res     = stat[in_word_reg.channel].done;
        out_word_next.high_ticks   = stat[in_word_reg.channel].high_ticks;
        out_word_next.high_wraps   = stat[in_word_reg.channel].high_wraps;
        out_word_next.period_ticks = stat[in_word_reg.channel].period_ticks;
        out_word_next.period_wraps = stat[in_word_reg.channel].period_wraps;
        out_word_next.holder       = owner_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_word_reg <= out_word_next;
        end
    end

    // The owner is a channel in the middle of a measurement, unless a word is being processed.
    a_own0_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (owner_reg == HOLD_CH0) |-> (stat[0].phase == PH_HIGH || stat[0].phase == PH_LOW
                                     || fire))
        else $error("channel zero owns timer outside a measurement");

    a_own1_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (owner_reg == HOLD_CH1) |-> (stat[1].phase == PH_HIGH || stat[1].phase == PH_LOW
                                     || fire))
        else $error("channel one owns timer outside a measurement");

    a_holder_match: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (out_word_reg.holder == owner_reg))
        else $error("reported holder differs from timer owner");

endmodule
